FILE: hw/rtl/mlm_pkg.sv
// Package: shared constants, commands and state type of the limb multiplier
package mlm_pkg;
    localparam int MAX_LIMBS_DEF = 16;
    localparam int LIMB_BITS_DEF = 32;
    localparam int IDX_W         = 4;
    localparam int LEN_W         = 5;
    localparam int PIDX_W        = 5;
    localparam int OVF_W         = 8;

    localparam logic [1:0] CMD_LOAD_X = 2'd0;
    localparam logic [1:0] CMD_LOAD_Y = 2'd1;
    localparam logic [1:0] CMD_START  = 2'd2;

    localparam logic CFG_X_LEN = 1'b0;
    localparam logic CFG_Y_LEN = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_EMIT
    } t_state;
endpackage

FILE: hw/rtl/mlm_cell.sv
// One limb cell: x limb on a rotating chain, y limb held in place
module mlm_cell #(
    parameter int LIMB_BITS = mlm_pkg::LIMB_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_load_x,
    input  logic                 i_load_y,
    input  logic [LIMB_BITS-1:0] i_data,
    input  logic                 i_shift,
    input  logic [LIMB_BITS-1:0] i_shift_in,
    output logic [LIMB_BITS-1:0] o_x,
    output logic [LIMB_BITS-1:0] o_y
);
    logic [LIMB_BITS-1:0] r_x;
    logic [LIMB_BITS-1:0] r_y;

    // x takes a load or the neighbor's limb; y only loads
    always_ff @(posedge i_clk) begin
        if (i_load_x) begin
            r_x <= i_data;
        end else if (i_shift) begin
            r_x <= i_shift_in;
        end
        if (i_load_y) begin
            r_y <= i_data;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
endmodule

FILE: hw/rtl/multiprecision_limb_multiplier.sv
// Top level: multi-limb schoolbook multiplier, column-wise, over a chain of limb cells
//
//  channel | direction | handshake               | payload
//  in      | sink      | i_in_valid / o_in_stall | cmd, limb_index, limb_value
//  out     | source    | o_out_valid/i_out_stall | product_limb, product_index, last
//  cfg     | sink      | i_cfg_we                | i_cfg_index, i_cfg_data
//
// A start works column by column: each column rotates the x chain through its lx
// active limbs past one multiplier, then the DRAIN1 and DRAIN2 states drain the
// multiply and accumulate stages and the EMIT state emits the limb.
// Reset is synchronous, active low, and clears control and accumulator.
// Output stall holds the emit step; input is stalled for the whole run.
module multiprecision_limb_multiplier #(
    parameter int MAX_LIMBS = mlm_pkg::MAX_LIMBS_DEF,
    parameter int LIMB_BITS = mlm_pkg::LIMB_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_cmd,
    input  logic [mlm_pkg::IDX_W-1:0]    i_limb_index,
    input  logic [LIMB_BITS-1:0]         i_limb_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [LIMB_BITS-1:0]         o_product_limb,
    output logic [mlm_pkg::PIDX_W-1:0]   o_product_index,
    output logic                         o_last,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [mlm_pkg::LEN_W-1:0]    i_cfg_data
);
    import mlm_pkg::*;

    localparam int IW  = $clog2(MAX_LIMBS + 1);
    localparam int KW  = $clog2(2 * MAX_LIMBS + 1);
    localparam int YAW = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1;
    localparam int AW  = 2 * LIMB_BITS + OVF_W;

    t_state               r_state, n_state;
    logic [LEN_W-1:0]     r_x_len, r_y_len;
    logic [IW-1:0]        r_i, n_i;
    logic [KW-1:0]        r_k, n_k;
    logic [LIMB_BITS-1:0] r_a, r_b;
    logic [2*LIMB_BITS-1:0] r_prod;
    logic [AW-1:0]        r_acc;
    logic                 r_out_valid;
    logic [LIMB_BITS-1:0] r_out_limb;
    logic [PIDX_W-1:0]    r_out_idx;
    logic                 r_out_last;

    logic [IW-1:0]        lx, ly;
    logic [KW-1:0]        lr;
    logic                 in_fire, issue, emit, out_free;
    logic [KW-1:0]        jdiff;
    logic                 y_ok;
    logic [LIMB_BITS-1:0] x_cell [MAX_LIMBS];
    logic [LIMB_BITS-1:0] y_cell [MAX_LIMBS];

    // clamp lengths into 1..MAX_LIMBS
    always_comb begin
        if (r_x_len == '0) lx = IW'(1);
        else if (int'(r_x_len) > MAX_LIMBS) lx = IW'(MAX_LIMBS);
        else lx = IW'(r_x_len);
        if (r_y_len == '0) ly = IW'(1);
        else if (int'(r_y_len) > MAX_LIMBS) ly = IW'(MAX_LIMBS);
        else ly = IW'(r_y_len);
        lr = KW'(lx) + KW'(ly);
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_fire    = i_in_valid && !o_in_stall;
    assign issue      = (r_state == ST_ISSUE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign emit       = (r_state == ST_EMIT) && out_free;

    // cell chain: cell j rotates from j+1, the last active cell wraps to cell 0;
    // cells past the active length hold their limbs
    for (genvar j = 0; j < MAX_LIMBS; j++) begin : g_cell
        logic [LIMB_BITS-1:0] shift_in;
        logic                 hit;
        assign hit = in_fire && (int'(i_limb_index) == j);
        if (j == MAX_LIMBS - 1) begin : g_end
            assign shift_in = x_cell[0];
        end else begin : g_mid
            assign shift_in = (int'(lx) == j + 1) ? x_cell[0] : x_cell[j+1];
        end
        mlm_cell #(.LIMB_BITS(LIMB_BITS)) u_cell (
            .i_clk      (i_clk),
            .i_load_x   (hit && (i_cmd == CMD_LOAD_X)),
            .i_load_y   (hit && (i_cmd == CMD_LOAD_Y)),
            .i_data     (i_limb_value),
            .i_shift    (issue && (j < int'(lx))),
            .i_shift_in (shift_in),
            .o_x        (x_cell[j]),
            .o_y        (y_cell[j])
        );
    end

    // y partner index for this term
    assign jdiff = r_k - KW'(r_i);
    assign y_ok  = (r_k >= KW'(r_i)) && (jdiff < KW'(ly));

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_len <= LEN_W'(1);
            r_y_len <= LEN_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_X_LEN: r_x_len <= i_cfg_data;
                CFG_Y_LEN: r_y_len <= i_cfg_data;
                default:   r_x_len <= r_x_len;
            endcase
        end
    end

    // operand, product and accumulator stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a    <= '0;
            r_b    <= '0;
            r_prod <= '0;
            r_acc  <= '0;
        end else begin
            r_a    <= x_cell[0];
            r_b    <= (issue && y_ok) ? y_cell[jdiff[YAW-1:0]] : '0;
            r_prod <= r_a * r_b;
            if (r_state == ST_IDLE) begin
                r_acc <= '0;
            end else if (emit) begin
                r_acc <= r_acc >> LIMB_BITS;
            end else begin
                r_acc <= r_acc + AW'(r_prod);
            end
        end
    end

    // state register and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_k     = r_k;
        unique case (r_state)
            ST_IDLE: begin
                n_i = '0;
                n_k = '0;
                if (in_fire && (i_cmd == CMD_START)) n_state = ST_ISSUE;
            end
            ST_ISSUE: begin
                if (r_i == lx - IW'(1)) begin
                    n_i     = '0;
                    n_state = ST_DRAIN1;
                end else begin
                    n_i = r_i + IW'(1);
                end
            end
            ST_DRAIN1: n_state = ST_DRAIN2;
            ST_DRAIN2: n_state = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    if (r_k == lr - KW'(1)) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_k     = r_k + KW'(1);
                        n_state = ST_ISSUE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (emit) begin
            r_out_limb <= r_acc[LIMB_BITS-1:0];
            r_out_idx  <= PIDX_W'(r_k);
            r_out_last <= (r_k == lr - KW'(1));
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_product_limb  = r_out_limb;
    assign o_product_index = r_out_idx;
    assign o_last          = r_out_last;
endmodule

FILE: hw/rtl/mlm_checker.sv
// Checker: port-level properties of the limb multiplier, bound to the top level
module mlm_checker #(
    parameter int LIMB_BITS = mlm_pkg::LIMB_BITS_DEF
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic [LIMB_BITS-1:0]       o_product_limb,
    input logic [mlm_pkg::PIDX_W-1:0] o_product_index,
    input logic                       o_last
);
    // a stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_product_limb)
            && $stable(o_product_index) && $stable(o_last))
        else $error("stalled output beat changed");

    // mid-run limb pending means the block is still busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> o_in_stall)
        else $error("input taken during a run");

    // product has at least two limbs
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> o_product_index != '0)
        else $error("last beat at index zero");

    // limbs follow in order within a run
    a_next_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) && $past(o_out_valid, 2) && !$past(o_last, 2)
            |-> o_product_index == $past(o_product_index, 2) + 1'b1)
        else $error("product index out of order");
endmodule

bind multiprecision_limb_multiplier mlm_checker #(.LIMB_BITS(LIMB_BITS)) u_mlm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_product_limb  (o_product_limb),
    .o_product_index (o_product_index),
    .o_last          (o_last)
);

FILE: bench/tb.sv
// Testbench for the multi-limb schoolbook multiplier: scoreboard class and stimulus tasks
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mlm_pkg::*;

    typedef struct packed {
        logic [31:0] limb;
        logic [4:0]  pidx;
        logic        last;
    } t_prod_beat;

    // Scoreboard: mirrors limb stores and lengths, queues expected product limbs
    class product_board;
        logic [31:0] xs [16];
        logic [31:0] ys [16];
        logic [4:0]  xl_reg, yl_reg;
        t_prod_beat  pending [$];
        int          errors;

        function new();
            xl_reg = 5'd1;
            yl_reg = 5'd1;
            errors = 0;
            foreach (xs[i]) begin
                xs[i] = '0;
                ys[i] = '0;
            end
        endfunction

        function int eff_len(logic [4:0] v);
            if (v == 0) return 1;
            if (v > 16) return 16;
            return int'(v);
        endfunction

        function void set_len(logic idx, logic [4:0] v);
            if (idx == CFG_X_LEN) xl_reg = v;
            else yl_reg = v;
        endfunction

        // Accepted input beat: update stores or form the full product
        function void note_input(logic [1:0] cmd, logic [3:0] idx, logic [31:0] val);
            int lx, ly;
            logic [95:0] acc;
            t_prod_beat b;
            if (cmd == CMD_LOAD_X) xs[idx] = val;
            else if (cmd == CMD_LOAD_Y) ys[idx] = val;
            else if (cmd == CMD_START) begin
                lx = eff_len(xl_reg);
                ly = eff_len(yl_reg);
                acc = '0;
                for (int k = 0; k < lx + ly; k++) begin
                    for (int i = 0; i < lx; i++)
                        if (k >= i && k - i < ly)
                            acc += 96'(xs[i]) * 96'(ys[k - i]);
                    b.limb = acc[31:0];
                    b.pidx = 5'(k);
                    b.last = (k == lx + ly - 1);
                    pending.push_back(b);
                    acc = acc >> 32;
                end
            end
        endfunction

        // Accepted output beat: compare with the oldest expectation
        function void check(logic [31:0] limb, logic [4:0] pidx, logic last);
            t_prod_beat e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected beat limb=%h idx=%0d last=%0b",
                         $time, limb, pidx, last);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (limb !== e.limb) begin
                $display("%0t: product_limb exp=%h act=%h", $time, e.limb, limb);
                errors++;
            end
            if (pidx !== e.pidx) begin
                $display("%0t: product_index exp=%0d act=%0d", $time, e.pidx, pidx);
                errors++;
            end
            if (last !== e.last) begin
                $display("%0t: last exp=%0b act=%0b", $time, e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_cmd = '0;
    logic [3:0]  i_limb_index = '0;
    logic [31:0] i_limb_value = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_product_limb;
    logic [4:0]  o_product_index;
    logic        o_last;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [4:0]  i_cfg_data = '0;

    product_board board = new();
    logic [15:0] x_written = '0;
    logic [15:0] y_written = '0;
    bit          calm = 1'b0;
    int          n_items = 0;

    multiprecision_limb_multiplier u_dut (.*);

    always #5 i_clk = ~i_clk;

    // Output side: random stall, sample accepted beats
    always @(negedge i_clk)
        i_out_stall <= !calm && ($urandom_range(99) < 14);

    always @(posedge i_clk)
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check(o_product_limb, o_product_index, o_last);

    // Send one input beat and wait for acceptance, with a random gap after
    task automatic send(logic [1:0] cmd, logic [3:0] idx, logic [31:0] val);
        i_in_valid = 1'b1;
        i_cmd = cmd;
        i_limb_index = idx;
        i_limb_value = val;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        board.note_input(cmd, idx, val);
        if (cmd == CMD_LOAD_X) x_written[idx] = 1'b1;
        if (cmd == CMD_LOAD_Y) y_written[idx] = 1'b1;
        n_items++;
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 14) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b0;
    endtask

    function automatic logic [31:0] rand_limb();
        case ($urandom_range(5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Wait for all product beats, let the block settle, then write a length
    task automatic write_len(logic idx, logic [4:0] v);
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        board.set_len(idx, v);
    endtask

    // Start only after every limb that the run reads has been loaded
    task automatic start_run();
        for (int i = 0; i < board.eff_len(board.xl_reg); i++)
            if (!x_written[i]) send(CMD_LOAD_X, 4'(i), rand_limb());
        for (int i = 0; i < board.eff_len(board.yl_reg); i++)
            if (!y_written[i]) send(CMD_LOAD_Y, 4'(i), rand_limb());
        send(CMD_START, 4'($urandom), $urandom);
    endtask

    // Full operand load with random content, then start
    task automatic full_run();
        for (int i = 0; i < board.eff_len(board.xl_reg); i++)
            send(CMD_LOAD_X, 4'(i), rand_limb());
        for (int i = 0; i < board.eff_len(board.yl_reg); i++)
            send(CMD_LOAD_Y, 4'(i), rand_limb());
        send(CMD_START, 4'($urandom), $urandom);
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: single limbs at extremes, unknown command, odd lengths
        calm = 1'b1;
        send(CMD_LOAD_X, 4'd0, 32'hFFFF_FFFF);
        send(CMD_LOAD_Y, 4'd0, 32'hFFFF_FFFF);
        send(CMD_START, 4'd0, 32'h0);
        send(2'd3, 4'd15, 32'hFFFF_FFFF);
        send(CMD_LOAD_X, 4'd15, 32'hFFFF_FFFF);
        send(CMD_LOAD_Y, 4'd15, 32'h0);
        send(CMD_LOAD_X, 4'd0, 32'h0);
        send(CMD_START, 4'd15, 32'hFFFF_FFFF);
        calm = 1'b0;
        write_len(CFG_X_LEN, 5'd0);
        write_len(CFG_Y_LEN, 5'd0);
        start_run();
        write_len(CFG_X_LEN, 5'd2);
        write_len(CFG_Y_LEN, 5'd3);
        start_run();
        write_len(CFG_X_LEN, 5'd31);
        write_len(CFG_Y_LEN, 5'd1);
        start_run();
        write_len(CFG_X_LEN, 5'd16);
        write_len(CFG_Y_LEN, 5'd16);
        start_run();

        // Random: length phases, mostly well-formed runs, some noise
        while (n_items < 200) begin
            calm = (n_items > 120 && n_items < 160);
            if ($urandom_range(9) == 0) begin
                write_len(CFG_X_LEN, 5'($urandom_range(31)));
                write_len(CFG_Y_LEN, 5'($urandom_range(31)));
            end else begin
                write_len(CFG_X_LEN, 5'($urandom_range(1, 4)));
                write_len(CFG_Y_LEN, 5'($urandom_range(1, 4)));
            end
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(9))
                    0: send(2'd3, 4'($urandom), $urandom);
                    1: send(2'($urandom_range(1)), 4'($urandom), rand_limb());
                    2: start_run();
                    default: full_run();
                endcase
            end
        end

        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
        if (board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end
endmodule

FILE: multiprecision_limb_multiplier.f
hw/rtl/mlm_pkg.sv
hw/rtl/mlm_cell.sv
hw/rtl/multiprecision_limb_multiplier.sv
hw/rtl/mlm_checker.sv
bench/tb.sv
